>>> rtl/core/minimum_spanning_tree_kruskal_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the spanning tree block
// Clocked property checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef MINIMUM_SPANNING_TREE_KRUSKAL_ASSERT_SVH
`define MINIMUM_SPANNING_TREE_KRUSKAL_ASSERT_SVH
`ifndef SYNTHESIS
`define MSTK_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSTK_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSTK_CHECK(lbl, prop, msg)
`define MSTK_CHECK_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/mstk_pkg.sv
// ---------------------------------------------------------------------------
// mstk_pkg
// Types and constants shared by the spanning tree block.
// ---------------------------------------------------------------------------
package mstk_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;
  localparam logic [6:0] VERTEX_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [5:0]        src;
    logic [5:0]        dst;
    logic signed [15:0] wt;
  } edge_t;

  typedef struct packed {
    logic [5:0]         edge_source;
    logic [5:0]         edge_target;
    logic signed [15:0] edge_weight;
    logic               final_edge;
  } in_t;

  typedef struct packed {
    logic [5:0]         tree_source;
    logic [5:0]         tree_target;
    logic signed [15:0] tree_weight;
    logic [5:0]         tree_edge_count;
    logic               tree_valid;
    logic               store_overflow;
    logic               last_result;
  } out_t;

endpackage

>>> rtl/core/mstk_sort_cell.sv
// ---------------------------------------------------------------------------
// mstk_sort_cell
// One slot of the sorted edge chain: inserts in weight order, shifts out.
// ---------------------------------------------------------------------------
module mstk_sort_cell import mstk_pkg::*; (
  input  logic  clk,
  input  logic  load_en,
  input  logic  shift_en,
  input  logic  slot_valid,
  input  edge_t new_edge,
  input  logic  prev_ins,
  input  edge_t prev_edge,
  input  edge_t next_edge,
  output logic  ins,
  output edge_t edge_q
);

  edge_t edge_r;
  edge_t edge_nxt;

  // strict compare keeps equal weights in arrival order
  assign ins = slot_valid && (new_edge.wt < edge_r.wt);

  always_comb begin
    edge_nxt = edge_r;
    if (shift_en) begin
      edge_nxt = next_edge;
    end else if (load_en && (ins || !slot_valid)) begin
      edge_nxt = prev_ins ? prev_edge : new_edge;
    end
  end

  always_ff @(posedge clk) begin
    edge_r <= edge_nxt;
  end

  assign edge_q = edge_r;

endmodule

>>> rtl/core/mstk_vertex_cell.sv
// ---------------------------------------------------------------------------
// mstk_vertex_cell
// Component label of one vertex, relabeled when two components merge.
// ---------------------------------------------------------------------------
module mstk_vertex_cell import mstk_pkg::*; #(
  parameter int VW  = 6,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          init,
  input  logic          merge,
  input  logic [VW-1:0] from_label,
  input  logic [VW-1:0] to_label,
  output logic [VW-1:0] label_q
);

  logic [VW-1:0] label_r;
  logic [VW-1:0] label_nxt;

  always_comb begin
    label_nxt = label_r;
    if (init) begin
      label_nxt = VW'(IDX);
    end else if (merge && (label_r == from_label)) begin
      label_nxt = to_label;
    end
  end

  always_ff @(posedge clk) begin
    label_r <= label_nxt;
  end

  assign label_q = label_r;

endmodule

>>> rtl/core/minimum_spanning_tree_kruskal.sv
// ---------------------------------------------------------------------------
// minimum_spanning_tree_kruskal
// Kruskal spanning tree over a sorted insertion chain and vertex label cells.
// ---------------------------------------------------------------------------
// Edges are taken one per cycle while busy is low; each in-range edge is
// inserted into its sorted place in a chain of MAX_EDGES cells in that same
// cycle unless the chain is full. The request carrying final_edge raises busy;
// the chain then shifts one edge per cycle out of its head, checked against
// the vertex label cells and merged in that cycle, until the tree is complete
// or the chain is empty. Tree edges appear in the cycle after the next one is
// found, each for a single cycle on out_strobe; the receiver cannot stall, so
// results must be taken as they come. No clearing pass follows reset.
module minimum_spanning_tree_kruskal import mstk_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  output logic       out_strobe,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  `include "minimum_spanning_tree_kruskal_assert.svh"

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int TW = $clog2(MAX_EDGES + 1);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t        state_r;
  logic [TW-1:0] total_r;
  logic          ovf_r;
  logic [6:0]    vc_r;
  logic          out_strobe_r;
  out_t          out_r;
  logic          pend_v_r;
  edge_t         pend_r;
  logic [5:0]    count_r;

  logic [6:0]    nv;
  logic [6:0]    need;
  logic          keep, full, take, load_en, vinit, done, shift_en, merge;
  edge_t         new_edge;
  edge_t         head;
  logic [VW-1:0] la, lb;

  logic          ins  [MAX_EDGES];
  edge_t         edge_q [MAX_EDGES];
  logic [VW-1:0] label_q [MAX_VERTICES];

  assign nv   = (vc_r > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vc_r;
  assign need = (nv == 7'd0) ? 7'd0 : nv - 7'd1;

  assign new_edge = '{src: in_data.edge_source, dst: in_data.edge_target,
                      wt: in_data.edge_weight};
  assign take     = (state_r == ST_IDLE) && start;
  assign keep     = ({1'b0, in_data.edge_source} < nv) && ({1'b0, in_data.edge_target} < nv);
  assign full     = (total_r == TW'(MAX_EDGES));
  assign load_en  = take && keep && !full;
  assign vinit    = take && in_data.final_edge;
  assign done     = (total_r == '0) || ({1'b0, count_r} == need);
  assign shift_en = (state_r == ST_SCAN) && !done;
  assign head     = edge_q[0];
  assign merge    = shift_en && (la != lb);

  // one-hot pick of the head endpoints' labels
  always_comb begin
    la = '0;
    lb = '0;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      if (head.src == 6'(v)) la = label_q[v];
      if (head.dst == 6'(v)) lb = label_q[v];
    end
  end

  for (genvar k = 0; k < MAX_EDGES; k++) begin : g_chain
    mstk_sort_cell u_cell (
      .clk       (clk),
      .load_en   (load_en),
      .shift_en  (shift_en),
      .slot_valid(TW'(k) < total_r),
      .new_edge  (new_edge),
      .prev_ins  ((k == 0) ? 1'b0 : ins[(k == 0) ? 0 : k - 1]),
      .prev_edge (edge_q[(k == 0) ? 0 : k - 1]),
      .next_edge (edge_q[(k == MAX_EDGES - 1) ? k : k + 1]),
      .ins       (ins[k]),
      .edge_q    (edge_q[k])
    );
  end

  for (genvar v = 0; v < MAX_VERTICES; v++) begin : g_vtx
    mstk_vertex_cell #(.VW(VW), .IDX(v)) u_vtx (
      .clk       (clk),
      .init      (vinit),
      .merge     (merge),
      .from_label(lb),
      .to_label  (la),
      .label_q   (label_q[v])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_r      <= '0;
      ovf_r        <= 1'b0;
      vc_r         <= VERTEX_COUNT_RST;
      out_strobe_r <= 1'b0;
      pend_v_r     <= 1'b0;
      count_r      <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_valid) begin
        vc_r <= cfg_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            if (keep) begin
              if (full) ovf_r <= 1'b1;
              else      total_r <= total_r + TW'(1);
            end
            if (in_data.final_edge) begin
              state_r  <= ST_SCAN;
              count_r  <= '0;
              pend_v_r <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (done) begin
            // flush the held edge as the last result, or report an empty tree
            out_strobe_r <= 1'b1;
            out_r <= '{tree_source: pend_v_r ? pend_r.src : 6'd0,
                       tree_target: pend_v_r ? pend_r.dst : 6'd0,
                       tree_weight: pend_v_r ? pend_r.wt : 16'sd0,
                       tree_edge_count: pend_v_r ? count_r : 6'd0,
                       tree_valid: pend_v_r, store_overflow: ovf_r,
                       last_result: 1'b1};
            state_r  <= ST_IDLE;
            total_r  <= '0;
            ovf_r    <= 1'b0;
            pend_v_r <= 1'b0;
          end else begin
            total_r <= total_r - TW'(1);
            if (la != lb) begin
              count_r  <= count_r + 6'd1;
              pend_r   <= head;
              pend_v_r <= 1'b1;
              if (pend_v_r) begin
                out_strobe_r <= 1'b1;
                out_r <= '{tree_source: pend_r.src, tree_target: pend_r.dst,
                           tree_weight: pend_r.wt, tree_edge_count: count_r,
                           tree_valid: 1'b1, store_overflow: ovf_r,
                           last_result: 1'b0};
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy       = (state_r == ST_SCAN);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  `MSTK_CHECK(a_final_starts_run, start && !busy && in_data.final_edge |=> busy,
              "final request did not start a run")
  `MSTK_CHECK(a_last_ends_run, out_strobe && out_data.last_result |-> !busy,
              "last result while still running")
  `MSTK_CHECK(a_empty_is_last, out_strobe && !out_data.tree_valid |-> out_data.last_result,
              "empty result not last")
  `MSTK_CHECK(a_count_bound, busy |-> {1'b0, count_r} <= need,
              "tree larger than vertex count allows")
  `MSTK_CHECK(a_total_bound, total_r <= TW'(MAX_EDGES), "edge count beyond store size")

endmodule

>>> bench/minimum_spanning_tree_kruskal_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// minimum_spanning_tree_kruskal_tb
// Loads weighted graphs edge by edge and checks every emitted tree edge
// against a local Kruskal predictor with a stable sort and union by rank.
// ---------------------------------------------------------------------------
module minimum_spanning_tree_kruskal_tb;
  import mstk_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE      = 8;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_t        in_data;
  logic       out_strobe;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_data;

  // predictor state
  logic [6:0] vertex_count;
  edge_t      loaded_edges[$];
  bit         store_full_seen;
  logic [5:0] parent_of[64];
  logic [2:0] rank_of[64];
  out_t       tree_q[$];

  int mismatches;
  int idle_cycles;
  bit no_gaps;

  minimum_spanning_tree_kruskal uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int root_of(int v);
    int g;
    g = 0;
    while (v != parent_of[v] && g < 64) begin
      v = parent_of[v];
      g++;
    end
    return v;
  endfunction

  task automatic build_tree();
    edge_t sorted[$];
    edge_t e;
    out_t  r;
    int    nv, need, cnt, j, ra, rb;
    nv = (vertex_count > 64) ? 64 : vertex_count;
    // stable insertion: equal weights keep arrival order
    foreach (loaded_edges[i]) begin
      e = loaded_edges[i];
      j = sorted.size();
      while (j > 0 && $signed(sorted[j-1].wt) > $signed(e.wt)) j--;
      sorted.insert(j, e);
    end
    for (int i = 0; i < 64; i++) begin
      parent_of[i] = i[5:0];
      rank_of[i]   = '0;
    end
    need = (nv > 0) ? nv - 1 : 0;
    cnt = 0;
    foreach (sorted[i]) begin
      if (cnt >= need) break;
      ra = root_of(sorted[i].src);
      rb = root_of(sorted[i].dst);
      if (ra == rb) continue;
      cnt++;
      r = '0;
      r.tree_source     = sorted[i].src;
      r.tree_target     = sorted[i].dst;
      r.tree_weight     = sorted[i].wt;
      r.tree_edge_count = cnt[5:0];
      r.tree_valid      = 1'b1;
      r.store_overflow  = store_full_seen;
      tree_q.push_back(r);
      if (rank_of[ra] < rank_of[rb]) begin
        parent_of[ra] = rb[5:0];
      end else if (rank_of[ra] > rank_of[rb]) begin
        parent_of[rb] = ra[5:0];
      end else begin
        parent_of[rb] = ra[5:0];
        rank_of[ra]   = rank_of[ra] + 3'd1;
      end
    end
    if (cnt == 0) begin
      r = '0;
      r.store_overflow = store_full_seen;
      r.last_result    = 1'b1;
      tree_q.push_back(r);
    end else begin
      tree_q[tree_q.size()-1].last_result = 1'b1;
    end
    loaded_edges    = {};
    store_full_seen = 1'b0;
  endtask

  task automatic predict_edge(in_t it);
    int nv;
    edge_t e;
    nv = (vertex_count > 64) ? 64 : vertex_count;
    if (it.edge_source < nv && it.edge_target < nv) begin
      if (loaded_edges.size() < STORE_DEPTH) begin
        e.src = it.edge_source;
        e.dst = it.edge_target;
        e.wt  = it.edge_weight;
        loaded_edges.push_back(e);
      end else begin
        store_full_seen = 1'b1;
      end
    end
    if (it.final_edge) build_tree();
  endtask

  // one request; start is left high so back-to-back requests need no toggle
  task automatic send_edge(logic [5:0] s, logic [5:0] t, logic [15:0] w, bit fin);
    in_t it;
    int gap;
    it.edge_source = s;
    it.edge_target = t;
    it.edge_weight = w;
    it.final_edge  = fin;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_edge(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (tree_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [6:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vertex_count = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (tree_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected tree edge %p", out_data);
      end else begin
        if (out_data.tree_source !== tree_q[0].tree_source ||
            out_data.tree_target !== tree_q[0].tree_target ||
            out_data.tree_weight !== tree_q[0].tree_weight ||
            out_data.tree_edge_count !== tree_q[0].tree_edge_count ||
            out_data.tree_valid !== tree_q[0].tree_valid ||
            out_data.store_overflow !== tree_q[0].store_overflow ||
            out_data.last_result !== tree_q[0].last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tree edge mismatch: expected %p actual %p", tree_q[0], out_data);
        end
        void'(tree_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("minimum_spanning_tree_kruskal_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_extremes();
    write_vertex_count(7'd64);
    send_edge(6'd0, 6'd63, 16'h8000, 1'b0);
    send_edge(6'd63, 6'd62, 16'h7fff, 1'b0);
    send_edge(6'd5, 6'd5, 16'h0000, 1'b0);        // self loop
    send_edge(6'd1, 6'd2, 16'hffff, 1'b0);
    send_edge(6'd2, 6'd1, 16'hffff, 1'b0);        // tie, redundant
    send_edge(6'd0, 6'd1, 16'hffff, 1'b0);
    send_edge(6'd42, 6'd21, 16'h5555, 1'b0);
    send_edge(6'd21, 6'd42, 16'haaaa, 1'b1);
  endtask

  task automatic test_out_of_range();
    write_vertex_count(7'd2);
    send_edge(6'd0, 6'd1, 16'd10, 1'b0);
    send_edge(6'd2, 6'd0, 16'd1, 1'b0);
    send_edge(6'd1, 6'd0, 16'd3, 1'b0);
    send_edge(6'd0, 6'd3, 16'd0, 1'b1);           // dropped edge still ends the graph
    write_vertex_count(7'd4);
    send_edge(6'd4, 6'd4, 16'd0, 1'b1);           // nothing stored: empty tree
  endtask

  task automatic test_tiny_counts();
    write_vertex_count(7'd0);
    send_edge(6'd0, 6'd0, 16'd7, 1'b1);
    write_vertex_count(7'd1);
    send_edge(6'd0, 6'd0, 16'd7, 1'b0);
    send_edge(6'd0, 6'd1, 16'd7, 1'b1);
    write_vertex_count(7'd127);                   // clamps to MAX_VERTICES
    send_edge(6'd63, 6'd0, 16'h8001, 1'b0);
    send_edge(6'd62, 6'd63, 16'h8001, 1'b1);
  endtask

  task automatic test_random_graphs();
    int sent, n, nv, pick;
    logic [15:0] w;
    sent = 0;
    while (sent < 152) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) write_vertex_count(7'($urandom_range(0, 127)));
      else if (pick < 4) write_vertex_count(7'd64);
      else write_vertex_count(7'($urandom_range(2, 16)));
      nv = (vertex_count > 64) ? 64 : vertex_count;
      if (nv < 2) nv = 2;
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: w = 16'($urandom_range(0, 3));       // ties
          1: w = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
          default: w = 16'($urandom());
        endcase
        if ($urandom_range(0, 9) == 0)
          send_edge(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), w, i == n - 1);
        else
          send_edge(6'($urandom_range(0, nv - 1)), 6'($urandom_range(0, nv - 1)), w,
                    i == n - 1);
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    no_gaps = 1'b0;
    vertex_count = VERTEX_COUNT_RST;
    store_full_seen = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_out_of_range();
    test_tiny_counts();
    test_random_graphs();
    wait_idle();
    if (mismatches == 0 && tree_q.size() == 0) begin
      $display("minimum_spanning_tree_kruskal_tb passed");
    end else begin
      $display("minimum_spanning_tree_kruskal_tb failed");
    end
    $finish;
  end

endmodule
